// ===== hw/rtl/atpls_pkg.sv =====
`default_nettype none

package atpls_pkg;

  localparam int DATA_W         = 10;
  localparam int SUM_W          = 14;
  localparam int DIV_W          = 20;
  localparam int DSR_W          = 10;
  localparam int DIV_STEPS      = 20;
  localparam int STEP_W         = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int GROUP_SIZE_DEF = 10;
  localparam int RECIP_W        = 18;
  localparam int AVG_SHIFT      = 18;
  localparam int AVG_PROD_W     = AVG_SHIFT + DATA_W;

  localparam logic [DATA_W-1:0] FULL_LEVEL = 10'd1023;
  localparam logic [DATA_W-1:0] ZERO_LEVEL = 10'd0;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_SCALE,
    ST_SPAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/atpls_div.sv =====
`default_nettype none

module atpls_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire atpls_pkg::div_req_t     req_i,
  output logic                         done_o,
  output logic [atpls_pkg::DIV_W-1:0]  quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [atpls_pkg::STEP_W-1:0]  step_q, step_d;
  logic [atpls_pkg::DSR_W-1:0]   rem_q, rem_d;
  logic [atpls_pkg::DIV_W-1:0]   quo_q, quo_d;
  logic [atpls_pkg::DSR_W-1:0]   dsr_q, dsr_d;
  logic [atpls_pkg::DSR_W:0]     trial;
  logic                          fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[atpls_pkg::DIV_W-1]};
    fits   = (trial >= {1'b0, dsr_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = atpls_pkg::STEP_W'(atpls_pkg::DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = atpls_pkg::DSR_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[atpls_pkg::DSR_W-1:0];
      end
      quo_d = {quo_q[atpls_pkg::DIV_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("divider started while busy");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("divider finished without done");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/averaged_two_point_level_scaler.sv =====
`default_nettype none

// Sums GROUP_SIZE samples, then scales the truncated average between the low and
// high marks to a level from 0 to 1023, clamped at both ends. A sample that does not
// close a group is taken without a stall. The closing sample holds the input while the
// AVG state forms the average by a reciprocal multiplication, the SCALE state compares
// it with the marks, and, unless the average is clamped or the marks are equal, a
// bit-serial divider that yields one quotient bit per cycle over 20 bits divides the
// scaled offset by the span between the marks. The next sample is accepted as soon as
// the result is handed to the output register, so a result still waiting there for
// the output side adds its stall cycles to the closing sample.
module averaged_two_point_level_scaler #(
  parameter int GROUP_SIZE = atpls_pkg::GROUP_SIZE_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [atpls_pkg::DATA_W-1:0]      sample_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [atpls_pkg::DATA_W-1:0]      level_o,
  input  wire                               cfg_we_i,
  input  wire  [atpls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [atpls_pkg::DATA_W-1:0]      cfg_data_i
);

  localparam int CNT_W = $clog2(GROUP_SIZE);
  localparam logic [atpls_pkg::RECIP_W-1:0] AVG_RECIP = atpls_pkg::RECIP_W'(
    ((1 << atpls_pkg::AVG_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);

  atpls_pkg::state_e                state_q, state_d;
  logic [atpls_pkg::SUM_W-1:0]      sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [atpls_pkg::DATA_W-1:0]     low_q, low_d, high_q, high_d;
  logic [atpls_pkg::DATA_W-1:0]     res_q, res_d;
  logic [atpls_pkg::DATA_W-1:0]     level_q, level_d;
  logic [atpls_pkg::DATA_W-1:0]     avg_q, avg_d;
  logic                             out_valid_q, out_valid_d;
  logic                             in_acc, last;
  logic [atpls_pkg::AVG_PROD_W-1:0] avg_prod;
  logic [atpls_pkg::DATA_W-1:0]     span, diff;
  logic [atpls_pkg::DIV_W-1:0]      prod;
  atpls_pkg::div_req_t              div_req;
  logic                             div_done;
  logic [atpls_pkg::DIV_W-1:0]      div_quo;

  atpls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_stall_o  = (state_q != atpls_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign sum_next    = sum_q + atpls_pkg::SUM_W'(sample_i);
  assign last        = (cnt_q == CNT_W'(GROUP_SIZE - 1));
  assign avg_prod    = atpls_pkg::AVG_PROD_W'(sum_q) * atpls_pkg::AVG_PROD_W'(AVG_RECIP);
  assign span        = high_q - low_q;
  assign diff        = avg_q - low_q;
  assign prod        = {diff, {atpls_pkg::DATA_W{1'b0}}} - atpls_pkg::DIV_W'(diff);

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        atpls_pkg::REG_LOW_MARK:  low_d  = cfg_data_i;
        atpls_pkg::REG_HIGH_MARK: high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d          = state_q;
    sum_d            = sum_q;
    cnt_d            = cnt_q;
    res_d            = res_q;
    avg_d            = avg_q;
    level_d          = level_q;
    out_valid_d      = out_valid_q && out_stall_i;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      atpls_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (last) begin
            sum_d   = sum_next;
            cnt_d   = '0;
            state_d = atpls_pkg::ST_AVG;
          end else begin
            sum_d = sum_next;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      atpls_pkg::ST_AVG: begin
        avg_d   = avg_prod[atpls_pkg::AVG_PROD_W-1:atpls_pkg::AVG_SHIFT];
        sum_d   = '0;
        state_d = atpls_pkg::ST_SCALE;
      end
      atpls_pkg::ST_SCALE: begin
        if (avg_q < low_q) begin
          res_d   = atpls_pkg::ZERO_LEVEL;
          state_d = atpls_pkg::ST_DONE;
        end else if (avg_q > high_q) begin
          res_d   = atpls_pkg::FULL_LEVEL;
          state_d = atpls_pkg::ST_DONE;
        end else if (span == '0) begin
          res_d   = atpls_pkg::ZERO_LEVEL;
          state_d = atpls_pkg::ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = prod;
          div_req.divisor  = span;
          state_d          = atpls_pkg::ST_SPAN;
        end
      end
      atpls_pkg::ST_SPAN: begin
        if (div_done) begin
          res_d   = div_quo[atpls_pkg::DATA_W-1:0];
          state_d = atpls_pkg::ST_DONE;
        end
      end
      atpls_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          level_d     = res_q;
          state_d     = atpls_pkg::ST_IDLE;
        end
      end
      default: state_d = atpls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atpls_pkg::ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      low_q       <= atpls_pkg::ZERO_LEVEL;
      high_q      <= atpls_pkg::FULL_LEVEL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    avg_q   <= avg_d;
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

`ifndef SYNTH
  a_count_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(GROUP_SIZE - 1))
    else $error("sample count beyond group size");

  a_scaled_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atpls_pkg::ST_SPAN && div_done) |->
      div_quo[atpls_pkg::DIV_W-1:atpls_pkg::DATA_W] == '0)
    else $error("scaled level exceeds full scale");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atpls_pkg::ST_DONE && state_d == atpls_pkg::ST_IDLE) |=>
      (out_valid_q && level_q == $past(res_q)))
    else $error("result not moved to output register");
`endif

endmodule

`default_nettype wire
